[rtl/core/bcs_pkg.sv]
package bcs_pkg;

	localparam int STEPS   = 6;
	localparam int STEP_W  = 3;
	localparam int IVL_W   = 16;
	localparam int SUM_W   = 19;
	localparam int CNT_W   = 8;
	localparam int BLANK_W = 14;

	// floor(x / 9) = (x * RECIP9) >> RECIP9_SH, exact for x below 2^22
	localparam logic [21:0] RECIP9    = 22'd3728271;
	localparam int          RECIP9_SH = 25;
	// floor(x / 36) = (x * RECIP36) >> RECIP36_SH, exact for x below 2^21
	localparam logic [18:0] RECIP36    = 19'd466034;
	localparam int          RECIP36_SH = 24;

	typedef enum logic [1:0] {
		CFG_SETTLE = 2'd0,
		CFG_FAIL   = 2'd1
	} cfg_idx_t;

	typedef enum logic {
		REQ_ARM    = 1'b0,
		REQ_EXPIRE = 1'b1
	} req_t;

	typedef enum logic {
		ACT_COMMUTATE = 1'b0,
		ACT_REARM     = 1'b1
	} act_t;

	typedef struct packed {
		act_t               action;
		logic [STEP_W-1:0]  step;
		logic [SUM_W-1:0]   filt_old;
		logic [SUM_W-1:0]   filt_new;
		logic [IVL_W-1:0]   ivl;
		logic               check;
	} comm_t;

	typedef struct packed {
		act_t               action;
		logic [STEP_W-1:0]  step;
		logic [BLANK_W-1:0] blank_delay;
		logic               stall_res;
	} res_t;

endpackage

[rtl/core/bcs_seq.sv]
module bcs_seq import bcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  req_t             req_type,
	input  logic [IVL_W-1:0] interval,
	input  logic             run_closed,
	input  logic [CNT_W-1:0] settle_count,
	output logic             has_res,
	output comm_t            comm_s2
);

	typedef enum logic [1:0] {
		PH_AWAIT = 2'd0,
		PH_BLANK = 2'd1,
		PH_IDLE  = 2'd2
	} phase_t;

	phase_t            phase_q;
	logic [STEP_W-1:0] step_q;
	logic [IVL_W-1:0]  ivl_q;
	logic [IVL_W-1:0]  ring_q [STEPS];
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  filt_q;
	logic [CNT_W-1:0]  ccnt_q;

	logic              commute;
	logic              rearm;
	logic [STEP_W-1:0] step_nx;
	logic [SUM_W-1:0]  sum_nx;
	logic [SUM_W+3:0]  filt_acc;
	logic [SUM_W-1:0]  filt_nx;
	logic [CNT_W-1:0]  ccnt_nx;

	always_comb begin
		commute = 1'b0;
		rearm   = 1'b0;
		if (req_type == REQ_EXPIRE) begin
			unique case (phase_q)
				PH_AWAIT: commute = run_closed;
				PH_BLANK: rearm = 1'b1;
				default: ;
			endcase
		end
	end

	assign has_res = commute | rearm;

	assign step_nx  = (step_q == STEP_W'(STEPS - 1)) ? '0 : step_q + STEP_W'(1);
	assign sum_nx   = sum_q - SUM_W'(ring_q[step_nx]) + SUM_W'(ivl_q);
	// 7 * filt + sum, then drop three bits
	assign filt_acc = (SUM_W+4)'({filt_q, 3'b000}) - (SUM_W+4)'(filt_q)
	                + (SUM_W+4)'(sum_nx);
	assign filt_nx  = filt_acc[SUM_W+2:3];
	assign ccnt_nx  = (ccnt_q == {CNT_W{1'b1}}) ? ccnt_q : ccnt_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			ivl_q   <= '0;
			for (int i = 0; i < STEPS; i++) begin
				ring_q[i] <= '0;
			end
			sum_q   <= '0;
			filt_q  <= '0;
			ccnt_q  <= '0;
			comm_s2 <= '0;
		end else if (go) begin
			if (req_type == REQ_ARM) begin
				ivl_q   <= interval;
				phase_q <= PH_AWAIT;
			end else if (commute) begin
				phase_q         <= PH_BLANK;
				step_q          <= step_nx;
				ring_q[step_nx] <= ivl_q;
				sum_q           <= sum_nx;
				filt_q          <= filt_nx;
				ccnt_q          <= ccnt_nx;
			end else if (rearm) begin
				phase_q <= PH_IDLE;
			end
			comm_s2.action   <= rearm ? ACT_REARM : ACT_COMMUTATE;
			comm_s2.step     <= commute ? step_nx : step_q;
			comm_s2.filt_old <= filt_q;
			comm_s2.filt_new <= filt_nx;
			comm_s2.ivl      <= ivl_q;
			comm_s2.check    <= commute && (ccnt_nx > settle_count);
		end
	end

endmodule

[rtl/core/bcs_chk.sv]
module bcs_chk import bcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  comm_t            comm_s2,
	input  logic [CNT_W-1:0] fail_limit,
	output res_t             res_q
);

	localparam int LO_PW = SUM_W + 22;
	localparam int HI_PW = SUM_W + 23;
	localparam int BL_PW = SUM_W + 19;

	logic [CNT_W-1:0]   fcnt_q;
	logic [LO_PW-1:0]   lo_prod;
	logic [HI_PW-1:0]   hi_prod;
	logic [BL_PW-1:0]   bl_prod;
	logic [IVL_W-1:0]   lo;
	logic [IVL_W:0]     hi;
	logic [BLANK_W-1:0] blank;
	logic               in_win;
	logic               checked;
	logic [CNT_W-1:0]   fcnt_nx;

	// window bounds filt/9 and 2*filt/9, blanking old filt/36
	assign lo_prod = LO_PW'(comm_s2.filt_new) * LO_PW'(RECIP9);
	assign hi_prod = HI_PW'({comm_s2.filt_new, 1'b0}) * HI_PW'(RECIP9);
	assign bl_prod = BL_PW'(comm_s2.filt_old) * BL_PW'(RECIP36);
	assign lo      = lo_prod[RECIP9_SH +: IVL_W];
	assign hi      = hi_prod[RECIP9_SH +: IVL_W+1];
	assign blank   = bl_prod[RECIP36_SH +: BLANK_W];

	assign in_win  = (comm_s2.ivl > lo) && ((IVL_W+1)'(comm_s2.ivl) < hi);
	assign checked = (comm_s2.action == ACT_COMMUTATE) && comm_s2.check;

	always_comb begin
		if (in_win) begin
			fcnt_nx = (fcnt_q == '0) ? fcnt_q : fcnt_q - CNT_W'(1);
		end else begin
			fcnt_nx = (fcnt_q == {CNT_W{1'b1}}) ? fcnt_q : fcnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (go && checked) begin
			fcnt_q <= fcnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q.action      <= comm_s2.action;
			res_q.step        <= comm_s2.step;
			res_q.blank_delay <= (comm_s2.action == ACT_COMMUTATE) ? blank : '0;
			res_q.stall_res   <= checked && !in_win && (fcnt_nx > fail_limit);
		end
	end

endmodule

[rtl/core/bldc_commutation_sequencer_unit.sv]
// Six-step sensorless commutation sequencer.
// Input stream s_*: s_tuser is the request kind (0 arm with interval, 1 timer
// expiry); s_tdata carries the 60-degree interval and the closed-loop flag.
// Output stream m_*: s_tuser-style kind on m_tuser (0 commutate and blank,
// 1 comparator re-arm); m_tdata carries step, blanking delay and stall flag.
// Arms update state but give no item; expiries that cause no action give none.
// Pipeline is input register, sequencer stage and window check stage, whose
// register is the output register; an item moves through each as room allows.
// One item per cycle is accepted while the pipeline flows; the sequencer
// state is updated as each item passes the sequencer stage, so successive items chain.
// When m_tready is low the output register holds; the two inner stages fill
// and s_tready drops only once all three are occupied.
// Reset clears phase to idle, step, interval ring, sums and counters, and
// loads settle_count 12 and fail_limit 10. cfg_wen writes register cfg_idx
// (0 settle_count, 1 fail_limit) and is to be used only while idle.
module bldc_commutation_sequencer_unit import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // interval[15:0], run_closed[16], zero pad
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // step[2:0], blank_delay[16:3], stall_res[17], zero pad
	output logic        m_tuser,   // action
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_wdata
);

	logic [CNT_W-1:0] settle_q;
	logic [CNT_W-1:0] fail_q;

	logic             s1_v_q;
	req_t             req_s1;
	logic [IVL_W-1:0] ivl_s1;
	logic             run_s1;
	logic             s2_v_q;
	logic             out_v_q;

	logic             out_room;
	logic             s2_room;
	logic             s2_go;
	logic             s1_go;
	logic             s_acc;
	logic             has_res;
	comm_t            comm_s2;
	res_t             res_q;

	assign out_room = !out_v_q || m_tready;
	assign s2_go    = s2_v_q && out_room;
	assign s2_room  = !s2_v_q || out_room;
	assign s1_go    = s1_v_q && s2_room;
	assign s_tready = !s1_v_q || s2_room;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= CNT_W'(12);
			fail_q   <= CNT_W'(10);
		end else if (cfg_wen) begin
			if (cfg_idx == CFG_SETTLE) begin
				settle_q <= cfg_wdata;
			end else if (cfg_idx == CFG_FAIL) begin
				fail_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_acc) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go) begin
				s2_v_q <= has_res;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_s1 <= req_t'(s_tuser);
			ivl_s1 <= s_tdata[IVL_W-1:0];
			run_s1 <= s_tdata[IVL_W];
		end
	end

	bcs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (s1_go),
		.req_type     (req_s1),
		.interval     (ivl_s1),
		.run_closed   (run_s1),
		.settle_count (settle_q),
		.has_res      (has_res),
		.comm_s2      (comm_s2)
	);

	bcs_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (s2_go),
		.comm_s2    (comm_s2),
		.fail_limit (fail_q),
		.res_q      (res_q)
	);

	assign m_tvalid = out_v_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {6'b000000, res_q.stall_res, res_q.blank_delay, res_q.step};

	a_rearm_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_REARM) |->
			(res_q.blank_delay == '0) && !res_q.stall_res)
		else $error("re-arm item carries blanking or stall");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_q.step < STEP_W'(STEPS)))
		else $error("step out of range");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && !s2_go |=> s2_v_q)
		else $error("pending result dropped");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_go |=> s1_v_q)
		else $error("pending input item dropped");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> s_tready)
		else $error("input refused with empty input register");

endmodule

[tb/tb_bldc_commutation_sequencer_unit.sv]
`timescale 1ns / 1ps

module tb_bldc_commutation_sequencer_unit import bcs_pkg::*;;

	typedef enum logic [1:0] {
		SEQ_AWAIT = 2'd0,
		SEQ_BLANK = 2'd1,
		SEQ_IDLE  = 2'd2
	} seq_phase_t;

	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;
	localparam int QUIET_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 270;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // interval[15:0], run_closed[16], zero pad
	logic        s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // step[2:0], blank_delay[16:3], stall_res[17], zero pad
	logic        m_tuser;   // action
	logic        cfg_wen;
	logic [1:0]  cfg_idx;
	logic [7:0]  cfg_wdata;

	bldc_commutation_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	seq_phase_t        seq_phase;
	logic [STEP_W-1:0] step_cur;
	logic [IVL_W-1:0]  held_ivl;
	logic [IVL_W-1:0]  ivl_ring [STEPS];
	logic [SUM_W-1:0]  ring_total;
	logic [SUM_W-1:0]  filt;
	logic [CNT_W-1:0]  comm_cnt;
	logic [CNT_W-1:0]  fail_cnt;
	logic [CNT_W-1:0]  settle_cfg;
	logic [CNT_W-1:0]  limit_cfg;

	res_t pending_results[$];

	int gap_max;
	int rx_max;
	int rx_hold;
	int rx_wait;
	int items_sent;
	int results_checked;
	int failures;
	int commutations;
	int rearms;
	int stall_flags;
	int settings_used;

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("MISMATCH at %0t: %s", $time, msg);
	endfunction

	task automatic advance_sequencer(input req_t req, input logic [IVL_W-1:0] ivl,
			input logic run);
		res_t        r;
		logic [31:0] f;
		logic [31:0] lo;
		logic [31:0] hi;
		r = '0;
		if (req == REQ_ARM) begin
			held_ivl = ivl;
			seq_phase = SEQ_AWAIT;
		end else if (seq_phase == SEQ_AWAIT && run) begin
			r.action = ACT_COMMUTATE;
			r.blank_delay = BLANK_W'(filt / 19'd36);
			step_cur = (step_cur == STEPS - 1) ? '0 : step_cur + 1'b1;
			seq_phase = SEQ_BLANK;
			ring_total = ring_total - ivl_ring[step_cur] + held_ivl;
			ivl_ring[step_cur] = held_ivl;
			if (comm_cnt != '1)
				comm_cnt++;
			f = (32'(filt) * 32'd7 + 32'(ring_total)) >> 3;
			filt = f[SUM_W-1:0];
			if (comm_cnt > settle_cfg) begin
				lo = 32'(filt) * 32'd40 / 32'd360;
				hi = 32'(filt) * 32'd80 / 32'd360;
				if (held_ivl > lo && held_ivl < hi) begin
					if (fail_cnt != '0)
						fail_cnt--;
				end else begin
					if (fail_cnt != '1)
						fail_cnt++;
					r.stall_res = (fail_cnt > limit_cfg);
				end
			end
			r.step = step_cur;
			pending_results.push_back(r);
			commutations++;
			stall_flags += r.stall_res;
		end else if (seq_phase == SEQ_BLANK) begin
			seq_phase = SEQ_IDLE;
			r.action = ACT_REARM;
			r.step = step_cur;
			pending_results.push_back(r);
			rearms++;
		end
	endtask

	// interval that lands on a window bound for the next commutation
	function automatic logic [IVL_W-1:0] window_edge(input bit upper);
		logic [IVL_W-1:0]  v;
		logic [STEP_W-1:0] nxt;
		logic [SUM_W-1:0]  tot;
		logic [31:0]       f;
		v = '0;
		nxt = (step_cur == STEPS - 1) ? '0 : step_cur + 1'b1;
		repeat (8) begin
			tot = ring_total - ivl_ring[nxt] + v;
			f = ((32'(filt) * 32'd7 + 32'(tot)) >> 3) & 32'h7FFFF;
			v = IVL_W'(upper ? f * 32'd80 / 32'd360 : f * 32'd40 / 32'd360);
		end
		return v;
	endfunction

	task automatic send_item(input req_t req, input logic [IVL_W-1:0] ivl, input logic run);
		int gap;
		gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {7'd0, run, ivl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_sequencer(req, ivl, run);
		items_sent++;
	endtask

	task automatic commutate_once(input logic [IVL_W-1:0] ivl);
		send_item(REQ_ARM, ivl, 1'($urandom_range(1, 0)));
		send_item(REQ_EXPIRE, IVL_W'($urandom), 1'b1);
		send_item(REQ_EXPIRE, IVL_W'($urandom), 1'b1);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int n = 0; n < 5000 && pending_results.size() > 0; n++)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == CFG_SETTLE)
			settle_cfg = val;
		else if (idx == CFG_FAIL)
			limit_cfg = val;
	endtask

	task automatic apply_setting(input logic [CNT_W-1:0] settle, input logic [CNT_W-1:0] limit);
		wait_quiet();
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_FAIL, limit);
		write_reg(CFG_SPARE_LO, CNT_W'($urandom));
		write_reg(CFG_SPARE_HI, CNT_W'($urandom));
		settings_used++;
	endtask

	task automatic test_reset_behavior();
		gap_max = 15;
		rx_max = 15;
		// expiry while idle after reset
		send_item(REQ_EXPIRE, 16'h1234, 1'b1);
		send_item(REQ_ARM, 16'h0000, 1'b0);
		// open loop expiry is ignored
		send_item(REQ_EXPIRE, 16'hFFFF, 1'b0);
		send_item(REQ_EXPIRE, 16'h0000, 1'b1);
		send_item(REQ_EXPIRE, 16'hFFFF, 1'b1);
		send_item(REQ_EXPIRE, 16'h5555, 1'b1);
		send_item(REQ_ARM, 16'hFFFF, 1'b1);
		// re-arm while awaiting commutation
		send_item(REQ_ARM, 16'h2AAA, 1'b0);
		send_item(REQ_EXPIRE, 16'h0000, 1'b1);
		// arm during blanking
		send_item(REQ_ARM, 16'hFFFF, 1'b1);
		send_item(REQ_EXPIRE, 16'hAAAA, 1'b1);
		send_item(REQ_EXPIRE, 16'h5555, 1'b1);
	endtask

	task automatic test_window_edges();
		logic [IVL_W-1:0] lo_edge;
		logic [IVL_W-1:0] hi_edge;
		apply_setting(8'd0, 8'd0);
		commutate_once(16'd9000);
		lo_edge = window_edge(1'b0);
		commutate_once(lo_edge);
		hi_edge = window_edge(1'b1);
		commutate_once(hi_edge);
		lo_edge = window_edge(1'b0);
		hi_edge = window_edge(1'b1);
		commutate_once(lo_edge + (hi_edge - lo_edge) / 2);
	endtask

	task automatic test_random_runs();
		int               phase_items;
		int               base;
		int               span;
		int               pick;
		int               len;
		logic [IVL_W-1:0] ivl;
		for (int k = 0; k < 7; k++) begin
			case (k)
			0: apply_setting(8'd12, 8'd10);
			1: apply_setting(8'd0, 8'd0);
			2: apply_setting(8'd255, 8'd255);
			3: apply_setting(8'd0, 8'd255);
			4: apply_setting(8'd255, 8'd0);
			default: apply_setting(CNT_W'($urandom_range(20, 0)), CNT_W'($urandom_range(12, 0)));
			endcase
			phase_items = items_sent;
			while (items_sent - phase_items < PHASE_ITEMS) begin
				gap_max = (k == 0 || $urandom_range(3, 0) == 0) ? 0 : 15;
				rx_max = (k == 0 || $urandom_range(3, 0) == 0) ? 0 : 15;
				base = ($urandom_range(7, 0) == 0) ? $urandom_range(54000, 300)
					: $urandom_range(20000, 300);
				len = $urandom_range(40, 8);
				for (int c = 0; c < len && items_sent - phase_items < PHASE_ITEMS; c++) begin
					span = base / 5;
					pick = $urandom_range(99, 0);
					ivl = IVL_W'(base - span + $urandom_range(2 * span, 0));
					if (pick < 6) begin
						send_item(req_t'($urandom_range(1, 0)), IVL_W'($urandom),
							1'($urandom_range(1, 0)));
					end else if (pick < 12) begin
						if (pick[0])
							commutate_once((base > 21845) ? 16'hFFFF : IVL_W'(base * 3));
						else
							commutate_once(IVL_W'(base / 3));
					end else if (pick < 20) begin
						send_item(REQ_ARM, ivl, 1'b0);
						send_item(REQ_EXPIRE, IVL_W'($urandom), 1'b0);
						send_item(REQ_EXPIRE, IVL_W'($urandom), 1'b1);
						send_item(REQ_EXPIRE, IVL_W'($urandom), 1'b1);
					end else if (pick < 27) begin
						send_item(REQ_ARM, IVL_W'($urandom), 1'b1);
						commutate_once(ivl);
					end else if (pick < 33) begin
						commutate_once(ivl);
						send_item(REQ_EXPIRE, IVL_W'($urandom), 1'($urandom_range(1, 0)));
					end else begin
						commutate_once(ivl);
					end
					if ($urandom_range(9, 0) == 0) begin
						base = base + $urandom_range(base / 16, 0) - base / 32;
						if (base > 54000)
							base = 54000;
						if (base < 300)
							base = 300;
					end
				end
			end
		end
	endtask

	task automatic test_output_backpressure();
		apply_setting(8'd4, 8'd3);
		gap_max = 0;
		rx_max = 0;
		rx_hold = HOLD_CYCLES;
		repeat (15) commutate_once(IVL_W'($urandom_range(5000, 1000)));
		gap_max = 15;
		rx_max = 15;
		repeat (5) commutate_once(IVL_W'($urandom_range(5000, 1000)));
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait = (rx_max > 0) ? $urandom_range(rx_max, 0) : 0;
			results_checked++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("item with nothing pending: action %0d step %0d",
					m_tuser, m_tdata[2:0]));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.action || m_tdata[2:0] !== want.step
						|| m_tdata[16:3] !== want.blank_delay || m_tdata[17] !== want.stall_res)
					note_failure($sformatf({"expected action %0d step %0d blank %0d stall %0d,",
						" got action %0d step %0d blank %0d stall %0d"},
						want.action, want.step, want.blank_delay, want.stall_res,
						m_tuser, m_tdata[2:0], m_tdata[16:3], m_tdata[17]));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("timeout at %0t", $time);
		$display("** bldc_commutation_sequencer_unit: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		seq_phase = SEQ_IDLE;
		step_cur = '0;
		held_ivl = '0;
		foreach (ivl_ring[i])
			ivl_ring[i] = '0;
		ring_total = '0;
		filt = '0;
		comm_cnt = '0;
		fail_cnt = '0;
		settle_cfg = 8'd12;
		limit_cfg = 8'd10;
		gap_max = 0;
		rx_max = 0;
		rx_hold = 0;
		rx_wait = 0;
		items_sent = 0;
		results_checked = 0;
		failures = 0;
		commutations = 0;
		rearms = 0;
		stall_flags = 0;
		settings_used = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_behavior();
		test_window_edges();
		test_random_runs();
		test_output_backpressure();
		wait_quiet();

		if (pending_results.size() > 0)
			note_failure($sformatf("%0d expected items never arrived", pending_results.size()));
		$display("run covered %0d items in, %0d commutations, %0d re-arms, %0d stall flags",
			items_sent, commutations, rearms, stall_flags);
		$display("%0d register settings incl. extremes, %0d items checked, %0d-cycle output hold",
			settings_used, results_checked, HOLD_CYCLES);
		if (failures == 0) begin
			$display("** bldc_commutation_sequencer_unit: PASSED **");
		end else begin
			$display("%0d failures", failures);
			$display("** bldc_commutation_sequencer_unit: FAILED **");
		end
		$finish;
	end

endmodule

[bldc_commutation_sequencer_unit.f]
rtl/core/bcs_pkg.sv
rtl/core/bcs_seq.sv
rtl/core/bcs_chk.sv
rtl/core/bldc_commutation_sequencer_unit.sv
tb/tb_bldc_commutation_sequencer_unit.sv
